// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI host sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned CsdBytes    = 16;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_READ  = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_SYNC  = 3'd3,
    REQ_CAP   = 3'd4,
    REQ_SPI   = 3'd5,
    REQ_TICK  = 3'd6,
    REQ_WBYTE = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    CFG_READY_TO = 3'd0,
    CFG_TOKEN_TO = 3'd1,
    CFG_INIT_TO  = 3'd2,
    CFG_POLLS    = 3'd3,
    CFG_WAKE     = 3'd4
  } cfg_e;

  typedef enum logic [29:0] {
    P_IDLE    = 30'h0000_0001,
    P_WAKE    = 30'h0000_0002,
    P_CMD0    = 30'h0000_0004,
    P_CMD8    = 30'h0000_0008,
    P_R7      = 30'h0000_0010,
    P_V2LOOP  = 30'h0000_0020,
    P_CMD58   = 30'h0000_0040,
    P_OCR     = 30'h0000_0080,
    P_V1PROBE = 30'h0000_0100,
    P_V1LOOP  = 30'h0000_0200,
    P_CMD16   = 30'h0000_0400,
    P_RDCMD   = 30'h0000_0800,
    P_TOKEN   = 30'h0000_1000,
    P_DATA    = 30'h0000_2000,
    P_CRC     = 30'h0000_4000,
    P_STOP    = 30'h0000_8000,
    P_ACMD23  = 30'h0001_0000,
    P_WRCMD   = 30'h0002_0000,
    P_WRREADY = 30'h0004_0000,
    P_WRTOK   = 30'h0008_0000,
    P_WRNEED  = 30'h0010_0000,
    P_WRDATA  = 30'h0020_0000,
    P_WRCRC   = 30'h0040_0000,
    P_WRRESP  = 30'h0080_0000,
    P_STREADY = 30'h0100_0000,
    P_STTOK   = 30'h0200_0000,
    P_SYSEL   = 30'h0400_0000,
    P_SYRDY   = 30'h0800_0000,
    P_SYDES   = 30'h1000_0000,
    P_END     = 30'h2000_0000
  } phase_e;

  typedef enum logic [7:0] {
    E_OFF   = 8'b00000001,
    E_DESEL = 8'b00000010,
    E_SEL   = 8'b00000100,
    E_READY = 8'b00001000,
    E_FAIL  = 8'b00010000,
    E_FRAME = 8'b00100000,
    E_STUFF = 8'b01000000,
    E_POLL  = 8'b10000000
  } eng_e;

  localparam logic [3:0] KindMmc = 4'd1;
  localparam logic [3:0] KindSd1 = 4'd2;
  localparam logic [3:0] KindSd2 = 4'd4;
  localparam logic [3:0] KindBlk = 4'd8;
  localparam logic [7:0] Acmd41Code = 8'hA9;
  localparam logic [7:0] Acmd23Code = 8'h97;
  localparam logic [16:0] TmrMax = 17'h10000;

endpackage

// ===== rtl/sd_card_spi_host_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer
// Byte-level SD/MMC SPI-mode host: init, sector read/write, sync, capacity.
// ----------------------------------------------------------------------------
// The result of an accepted input beat is registered and comes out in the next cycle.
// Throughput: one beat per cycle; the output register is refilled when the
// result is taken or empty, so input ready only drops while a result stalls.
// Reset: asynchronous, active low; sequencer idle, configuration at defaults,
// chip select high, no card kind; the CSD bytes are undefined until read.
module sd_card_spi_host_sequencer
  import sdspi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] sector_address_i,
  input  logic [21:0] block_count_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  host_byte_i,
  input  logic        card_present_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        cs_level_o,
  output logic        slow_clock_o,
  output logic        rd_valid_o,
  output logic [7:0]  rd_byte_o,
  output logic        wr_need_o,
  output logic        done_res_o,
  output logic        ok_o,
  output logic [31:0] sector_total_o,
  output logic [3:0]  card_kind_o,
  output logic        inserted_o
);

  // configuration
  logic [15:0] ready_to_q, token_to_q, init_to_q;
  logic [7:0]  polls_cfg_q, wake_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_to_q  <= 16'd500;
      token_to_q  <= 16'd100;
      init_to_q   <= 16'd1000;
      polls_cfg_q <= 8'd10;
      wake_cfg_q  <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_READY_TO: ready_to_q  <= cfg_data_i;
        CFG_TOKEN_TO: token_to_q  <= cfg_data_i;
        CFG_INIT_TO:  init_to_q   <= cfg_data_i;
        CFG_POLLS:    polls_cfg_q <= cfg_data_i[7:0];
        CFG_WAKE:     wake_cfg_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // state
  phase_e      phase_q, phase_d;
  eng_e        eng_q, eng_d;
  logic [2:0]  job_q, job_d;
  logic [3:0]  kind_q, kind_d;
  logic        pres_q, pres_d;
  logic [16:0] elapsed_q, elapsed_d, ready_ms_q, ready_ms_d;
  logic [9:0]  idx_q, idx_d;
  logic [47:0] frame_q, frame_d;
  logic [7:0]  polls_q, polls_d, loop_q, loop_d, pcmd_q, pcmd_d;
  logic [21:0] blocks_q, blocks_d;
  logic [31:0] addr_q, addr_d, reply_q, reply_d, parg_q, parg_d;
  logic        app_q, app_d, csh_q, csh_d, slow_q, slow_d, endok_q, endok_d;
  logic [7:0]  csd_q [CsdBytes];
  logic        csd_we;
  logic [3:0]  csd_wa;

  // result
  logic        o_tx, o_rd, o_wr, o_done, o_ok;
  logic [7:0]  o_txb, o_rdb;
  logic [31:0] o_total;

  logic accept;
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // capacity decode from CSD
  logic [31:0] cap;
  logic [4:0]  cap_n;
  logic [31:0] cap_s;
  always_comb begin
    cap_n = 5'({1'b0, csd_q[5][3:0]}) + 5'(csd_q[10][7]) + 5'({csd_q[9][1:0], 1'b0}) + 5'd2;
    cap_s = 32'(csd_q[8][7:6]) + 32'({csd_q[7], 2'b00}) + 32'({csd_q[6][1:0], 10'd0}) + 32'd1;
    if (csd_q[0][7:6] == 2'd1) begin
      cap = (32'(csd_q[9]) + 32'({csd_q[8], 8'd0}) + 32'({csd_q[7][5:0], 16'd0}) + 32'd1) << 10;
    end else if (cap_n >= 5'd9) begin
      cap = cap_s << (cap_n - 5'd9);
    end else begin
      cap = cap_s >> (5'd9 - cap_n);
    end
  end

  logic [7:0] fb0;
  assign fb0 = frame_q[47:40];

  always_comb begin
    logic [7:0]  rx, cmd, arg8, crc, r;
    logic [31:0] arg, sh;
    logic [9:0]  lim;
    logic        go_issue, go_start, go_disp, go_fin, fin_ok, acc, act;
    logic [3:0]  ikind;
    logic        go_init;
    phase_e      ph_after;

    phase_d = phase_q; eng_d = eng_q; job_d = job_q; kind_d = kind_q;
    elapsed_d = elapsed_q; ready_ms_d = ready_ms_q; idx_d = idx_q;
    frame_d = frame_q; polls_d = polls_q; loop_d = loop_q; pcmd_d = pcmd_q;
    blocks_d = blocks_q; addr_d = addr_q; reply_d = reply_q; parg_d = parg_q;
    app_d = app_q; csh_d = csh_q; slow_d = slow_q; endok_d = endok_q;
    pres_d = pres_q; csd_we = 1'b0; csd_wa = idx_q[3:0];
    o_tx = 1'b0; o_txb = 8'd0; o_rd = 1'b0; o_rdb = 8'd0; o_wr = 1'b0;
    o_done = 1'b0; o_ok = 1'b0; o_total = 32'd0;
    rx = rx_byte_i; cmd = 8'd0; arg = 32'd0; arg8 = 8'd0; crc = 8'd1; r = 8'd0;
    sh = 32'd0; lim = 10'd0;
    go_issue = 1'b0; go_start = 1'b0; go_disp = 1'b0; go_fin = 1'b0;
    fin_ok = 1'b0; acc = 1'b0; act = 1'b0; ikind = 4'd0; go_init = 1'b0;
    ph_after = phase_q;

    if (accept) begin
      pres_d = card_present_i;
      if (!card_present_i) kind_d = 4'd0;
      unique case (req_e'(req_type_i))
        REQ_TICK: begin
          if (elapsed_q < TmrMax) elapsed_d = elapsed_q + 17'd1;
          if (ready_ms_q < TmrMax) ready_ms_d = ready_ms_q + 17'd1;
        end
        REQ_WBYTE: begin
          if (phase_q == P_WRNEED) begin
            o_tx = 1'b1; o_txb = host_byte_i; idx_d = idx_q + 10'd1;
            phase_d = P_WRDATA;
          end
        end
        REQ_SPI: begin
          if (eng_q != E_OFF) begin
            unique case (eng_q)
              E_DESEL: begin csh_d = 1'b0; o_tx = 1'b1; o_txb = 8'hFF; eng_d = E_SEL; end
              E_SEL: begin ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF; eng_d = E_READY; end
              E_READY: begin
                o_tx = 1'b1;
                if (rx == 8'hFF) begin
                  o_txb = fb0; idx_d = 10'd1; eng_d = E_FRAME;
                end else if (ready_ms_q > 17'(ready_to_q)) begin
                  csh_d = 1'b1; o_txb = 8'hFF; eng_d = E_FAIL;
                end else o_txb = 8'hFF;
              end
              E_FAIL: begin eng_d = E_OFF; r = 8'hFF; act = 1'b1; end
              E_FRAME: begin
                o_tx = 1'b1; o_txb = 8'hFF;
                if (idx_q < 10'd6) begin
                  sh = 32'(6'd40 - 6'({idx_q[2:0], 3'b000}));
                  o_txb = 8'(frame_q >> sh[5:0]); idx_d = idx_q + 10'd1;
                end else if (fb0[5:0] == 6'd12) eng_d = E_STUFF;
                else begin polls_d = polls_cfg_q; eng_d = E_POLL; end
              end
              E_STUFF: begin polls_d = polls_cfg_q; o_tx = 1'b1; o_txb = 8'hFF; eng_d = E_POLL; end
              default: begin
                polls_d = polls_q - 8'd1;
                if (rx[7] && polls_d != 8'd0) begin o_tx = 1'b1; o_txb = 8'hFF; end
                else begin eng_d = E_OFF; r = rx; act = 1'b1; end
              end
            endcase
            // command completion: app prefix or dispatch
            if (act) begin
              if (app_q) begin
                app_d = 1'b0;
                if (r > 8'd1) go_disp = 1'b1;
                else begin go_issue = 1'b1; cmd = pcmd_q; arg = parg_q; end
              end else go_disp = 1'b1;
            end
            if (go_disp) begin
              unique case (phase_q)
                P_CMD0: if (r == 8'd1) begin
                  elapsed_d = '0; go_start = 1'b1; cmd = 8'd8; arg = 32'h1AA; ph_after = P_CMD8;
                end else go_init = 1'b1;
                P_CMD8: if (r == 8'd1) begin
                  idx_d = '0; reply_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_R7;
                end else begin
                  go_start = 1'b1; cmd = Acmd41Code; arg = '0; ph_after = P_V1PROBE;
                end
                P_V2LOOP: if (r != 8'd0 || elapsed_q > 17'(init_to_q)) begin
                  if (elapsed_q > 17'(init_to_q)) go_init = 1'b1;
                  else begin go_start = 1'b1; cmd = Acmd41Code; arg = 32'h4000_0000;
                    ph_after = P_V2LOOP; end
                end else begin go_start = 1'b1; cmd = 8'd58; ph_after = P_CMD58; end
                P_CMD58: if (r == 8'd0) begin
                  idx_d = '0; reply_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_OCR;
                end else go_init = 1'b1;
                P_V1PROBE: begin
                  loop_d = (r <= 8'd1) ? Acmd41Code : 8'h01;
                  if (elapsed_q > 17'(init_to_q)) go_init = 1'b1;
                  else begin go_start = 1'b1; cmd = loop_d; ph_after = P_V1LOOP; end
                end
                P_V1LOOP: if (elapsed_q > 17'(init_to_q)) go_init = 1'b1;
                else if (r != 8'd0) begin go_start = 1'b1; cmd = loop_q; ph_after = P_V1LOOP; end
                else begin go_start = 1'b1; cmd = 8'd16; arg = 32'(SectorBytes);
                  ph_after = P_CMD16; end
                P_CMD16: begin
                  go_init = 1'b1;
                  ikind = (r != 8'd0) ? 4'd0 : ((loop_q == Acmd41Code) ? KindSd1 : KindMmc);
                end
                P_RDCMD: if (r == 8'd0) begin
                  ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_TOKEN;
                end else go_fin = 1'b1;
                P_STOP: begin go_fin = 1'b1; fin_ok = (blocks_q == 22'd0); end
                P_ACMD23: begin go_start = 1'b1; cmd = 8'd25; arg = addr_q; ph_after = P_WRCMD; end
                P_WRCMD: if (r == 8'd0) begin
                  ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_WRREADY;
                end else go_fin = 1'b1;
                default: go_fin = 1'b1;
              endcase
            end
          end else if (phase_q != P_IDLE && phase_q != P_WRNEED) begin
            lim = (job_q == 3'(REQ_CAP)) ? 10'(CsdBytes) : 10'(SectorBytes - 1);
            unique case (phase_q)
              P_WAKE: if (idx_q < 10'(wake_cfg_q)) begin
                o_tx = 1'b1; o_txb = 8'hFF; idx_d = idx_q + 10'd1;
              end else begin go_start = 1'b1; cmd = 8'd0; ph_after = P_CMD0; end
              P_R7, P_OCR: begin
                reply_d = {reply_q[23:0], rx}; idx_d = idx_q + 10'd1;
                if (idx_d < 10'd4) begin o_tx = 1'b1; o_txb = 8'hFF; end
                else if (phase_q == P_OCR) begin
                  go_init = 1'b1; ikind = reply_d[30] ? (KindSd2 | KindBlk) : KindSd2;
                end else if (reply_d[15:0] == 16'h01AA) begin
                  if (elapsed_q > 17'(init_to_q)) go_init = 1'b1;
                  else begin go_start = 1'b1; cmd = Acmd41Code; arg = 32'h4000_0000;
                    ph_after = P_V2LOOP; end
                end else go_init = 1'b1;
              end
              P_TOKEN: if (rx == 8'hFF && ready_ms_q <= 17'(token_to_q)) begin
                o_tx = 1'b1; o_txb = 8'hFF;
              end else if (rx == 8'hFE) begin
                idx_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_DATA;
              end else begin
                if (job_q == 3'(REQ_CAP)) go_fin = 1'b1;
                else if (loop_q == 8'd18) begin go_start = 1'b1; cmd = 8'd12; ph_after = P_STOP; end
                else begin go_fin = 1'b1; fin_ok = (blocks_q == 22'd0); end
              end
              P_DATA: begin
                if (job_q == 3'(REQ_CAP)) csd_we = 1'b1;
                else begin o_rd = 1'b1; o_rdb = rx; end
                idx_d = idx_q + 10'd1; o_tx = 1'b1; o_txb = 8'hFF;
                if ((job_q == 3'(REQ_CAP)) ? (idx_d >= lim) : (idx_q == lim)) begin
                  idx_d = '0; phase_d = P_CRC;
                end
              end
              P_CRC: begin
                idx_d = idx_q + 10'd1;
                if (idx_d < 10'd2) begin o_tx = 1'b1; o_txb = 8'hFF; end
                else if (job_q == 3'(REQ_CAP)) begin reply_d = cap; go_fin = 1'b1; fin_ok = 1'b1; end
                else begin
                  blocks_d = blocks_q - 22'd1;
                  if (blocks_d != 22'd0) begin
                    ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_TOKEN;
                  end else if (loop_q == 8'd18) begin
                    go_start = 1'b1; cmd = 8'd12; ph_after = P_STOP;
                  end else begin go_fin = 1'b1; fin_ok = 1'b1; end
                end
              end
              P_WRREADY: if (rx == 8'hFF) begin
                o_tx = 1'b1; o_txb = (loop_q == 8'd24) ? 8'hFE : 8'hFC; phase_d = P_WRTOK;
              end else if (ready_ms_q > 17'(ready_to_q)) begin
                if (loop_q == 8'd24) go_fin = 1'b1;
                else begin ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_STREADY; end
              end else begin o_tx = 1'b1; o_txb = 8'hFF; end
              P_WRTOK: begin idx_d = '0; o_wr = 1'b1; phase_d = P_WRNEED; end
              P_WRDATA: if (idx_q < 10'(SectorBytes - 1) || idx_q == 10'(SectorBytes - 1)) begin
                o_wr = 1'b1; phase_d = P_WRNEED;
              end else begin idx_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_WRCRC; end
              P_WRCRC: begin
                idx_d = idx_q + 10'd1; o_tx = 1'b1; o_txb = 8'hFF;
                if (idx_d >= 10'd2) phase_d = P_WRRESP;
              end
              P_WRRESP: begin
                acc = (rx[4:0] == 5'h05);
                if (acc) blocks_d = blocks_q - 22'd1;
                if (loop_q == 8'd24) begin go_fin = 1'b1; fin_ok = (blocks_d == 22'd0); end
                else begin
                  ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF;
                  phase_d = (acc && blocks_d != 22'd0) ? P_WRREADY : P_STREADY;
                end
              end
              P_STREADY: if (rx == 8'hFF) begin
                o_tx = 1'b1; o_txb = 8'hFD; phase_d = P_STTOK;
              end else if (ready_ms_q > 17'(ready_to_q)) go_fin = 1'b1;
              else begin o_tx = 1'b1; o_txb = 8'hFF; end
              P_STTOK: begin go_fin = 1'b1; fin_ok = (blocks_q == 22'd0); end
              P_SYSEL: begin ready_ms_d = '0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_SYRDY; end
              P_SYRDY: if (rx == 8'hFF) begin go_fin = 1'b1; fin_ok = 1'b1; end
              else if (ready_ms_q > 17'(ready_to_q)) begin
                csh_d = 1'b1; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_SYDES;
              end else begin o_tx = 1'b1; o_txb = 8'hFF; end
              P_SYDES: go_fin = 1'b1;
              P_END: begin
                o_done = 1'b1; o_ok = endok_q;
                o_total = (job_q == 3'(REQ_CAP) && endok_q) ? reply_q : 32'd0;
                if (job_q == 3'(REQ_INIT)) slow_d = 1'b0;
                phase_d = P_IDLE;
              end
              default: ;
            endcase
          end
        end
        default: begin
          // new request, only from idle; card kind as left after the presence check
          if (phase_q == P_IDLE) begin
            sh = kind_d[3] ? sector_address_i : {sector_address_i[22:0], 9'd0};
            if ((req_type_i == 3'(REQ_READ) || req_type_i == 3'(REQ_WRITE))
                && block_count_i == 22'd0) begin
              o_done = 1'b1; o_ok = 1'b1;
            end else begin
              job_d = req_type_i;
              unique case (req_e'(req_type_i))
                REQ_INIT: begin
                  slow_d = 1'b1; csh_d = 1'b1;
                  if (wake_cfg_q == 8'd0) begin go_start = 1'b1; cmd = 8'd0; ph_after = P_CMD0; end
                  else begin o_tx = 1'b1; o_txb = 8'hFF; idx_d = 10'd1; phase_d = P_WAKE; end
                end
                REQ_READ: begin
                  blocks_d = block_count_i; addr_d = sh;
                  loop_d = (block_count_i > 22'd1) ? 8'd18 : 8'd17;
                  go_start = 1'b1; cmd = loop_d; arg = sh; ph_after = P_RDCMD;
                end
                REQ_WRITE: begin
                  blocks_d = block_count_i; addr_d = sh; go_start = 1'b1;
                  if (block_count_i == 22'd1) begin
                    loop_d = 8'd24; cmd = 8'd24; arg = sh; ph_after = P_WRCMD;
                  end else begin
                    loop_d = 8'd25;
                    if ((kind_d & (KindSd1 | KindSd2)) != 4'd0) begin
                      cmd = Acmd23Code; arg = 32'(block_count_i); ph_after = P_ACMD23;
                    end else begin cmd = 8'd25; arg = sh; ph_after = P_WRCMD; end
                  end
                end
                REQ_SYNC: begin csh_d = 1'b0; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_SYSEL; end
                default: begin
                  reply_d = '0; loop_d = 8'd9; go_start = 1'b1; cmd = 8'd9; ph_after = P_RDCMD;
                end
              endcase
            end
          end
        end
      endcase

      // init end folds into finish
      if (go_init) begin kind_d = ikind; go_fin = 1'b1; fin_ok = (ikind != 4'd0); end
      // start a command, with CMD55 prefix for application commands
      if (go_start) begin
        phase_d = ph_after;
        if (cmd[7]) begin
          app_d = 1'b1; pcmd_d = {1'b0, cmd[6:0]}; parg_d = arg;
          cmd = 8'd55; arg = '0;
        end
        go_issue = 1'b1;
      end
      if (go_issue) begin
        crc = (cmd == 8'd0) ? 8'h95 : ((cmd == 8'd8) ? 8'h87 : 8'h01);
        arg8 = 8'h40 | {2'b00, cmd[5:0]};
        frame_d = {arg8, arg, crc};
        o_tx = 1'b1;
        if (cmd == 8'd12) begin o_txb = arg8; idx_d = 10'd1; eng_d = E_FRAME; end
        else begin csh_d = 1'b1; o_txb = 8'hFF; eng_d = E_DESEL; end
      end
      if (go_fin) begin
        endok_d = fin_ok; csh_d = 1'b1; o_tx = 1'b1; o_txb = 8'hFF; phase_d = P_END;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE; eng_q <= E_OFF; job_q <= 3'(REQ_INIT); kind_q <= '0;
      pres_q <= 1'b0; elapsed_q <= '0; ready_ms_q <= '0; idx_q <= '0;
      frame_q <= '0; polls_q <= '0; loop_q <= '0; pcmd_q <= '0; blocks_q <= '0;
      addr_q <= '0; reply_q <= '0; parg_q <= '0; app_q <= 1'b0; csh_q <= 1'b1;
      slow_q <= 1'b0; endok_q <= 1'b0;
    end else begin
      phase_q <= phase_d; eng_q <= eng_d; job_q <= job_d; kind_q <= kind_d;
      pres_q <= pres_d; elapsed_q <= elapsed_d; ready_ms_q <= ready_ms_d;
      idx_q <= idx_d; frame_q <= frame_d; polls_q <= polls_d; loop_q <= loop_d;
      pcmd_q <= pcmd_d; blocks_q <= blocks_d; addr_q <= addr_d; reply_q <= reply_d;
      parg_q <= parg_d; app_q <= app_d; csh_q <= csh_d; slow_q <= slow_d;
      endok_q <= endok_d;
    end
  end

  // hold CSD bytes
  always_ff @(posedge clk_i) begin
    if (csd_we) csd_q[csd_wa] <= rx_byte_i;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_o <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tx_valid_o <= o_tx; tx_byte_o <= o_txb; cs_level_o <= csh_d;
      slow_clock_o <= slow_d; rd_valid_o <= o_rd; rd_byte_o <= o_rdb;
      wr_need_o <= o_wr; done_res_o <= o_done; ok_o <= o_ok;
      sector_total_o <= o_total; card_kind_o <= kind_d; inserted_o <= pres_d;
    end
  end

  // checks
  a_eng_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(eng_q))
    else $error("engine state not one-hot");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o))
    else $error("stalled result changed");
  a_idle_eng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == P_IDLE |-> eng_q == E_OFF)
    else $error("engine busy while idle");

endmodule

// ===== verif/tb_sd_card_spi_host_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_card_spi_host_sequencer
// Self-checking bench for the SD/MMC SPI host sequencer. A cycle-free model of
// the sequencer predicts every result beat; the stimulus plays a card that
// mostly answers well (so init, reads, writes, sync and capacity run to the
// end) mixed with noise, ticks, stray beats and timeouts, under several
// register settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_sd_card_spi_host_sequencer;
  import sdspi_pkg::*;

  typedef struct {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_level;
    logic        slow_clock;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        wr_need;
    logic        done_res;
    logic        ok;
    logic [31:0] sector_total;
    logic [3:0]  card_kind;
    logic        inserted;
  } spi_result_t;

  // --------------------------------------------------------------------------
  // Sequencer predictor and result scoreboard
  // --------------------------------------------------------------------------
  class spi_host_scoreboard;
    int unsigned ready_limit, token_limit, init_limit;
    logic [7:0]  poll_limit, wake_count;

    phase_e      ph;
    eng_e        eng;
    req_e        job;
    logic [3:0]  kind;
    logic        present;
    int unsigned init_ms, wait_ms, idx;
    logic [47:0] frame;
    logic [7:0]  polls, loop_cmd, app_cmd;
    logic [21:0] blocks;
    logic [31:0] addr, reply, app_arg;
    logic [7:0]  csd[CsdBytes];
    bit          app_pend, cs_high, slow_clk, end_ok;

    spi_result_t res;
    spi_result_t expected_results[$];
    int unsigned mismatches, results_checked, requests_started, requests_ok;

    function new();
      ready_limit = 500; token_limit = 100; init_limit = 1000;
      poll_limit = 10; wake_count = 10;
      ph = P_IDLE; eng = E_OFF; job = REQ_INIT; kind = '0; present = 0;
      init_ms = 0; wait_ms = 0; idx = 0; frame = '0; polls = '0;
      loop_cmd = '0; app_cmd = '0; blocks = '0; addr = '0; reply = '0;
      app_arg = '0; app_pend = 0; cs_high = 1; slow_clk = 0; end_ok = 0;
      foreach (csd[i]) csd[i] = '0;
    endfunction

    function void set_reg(cfg_e sel, logic [15:0] val);
      case (sel)
        CFG_READY_TO: ready_limit = val;
        CFG_TOKEN_TO: token_limit = val;
        CFG_INIT_TO:  init_limit = val;
        CFG_POLLS:    poll_limit = val[7:0];
        CFG_WAKE:     wake_count = val[7:0];
        default: ;
      endcase
    endfunction

    function void shift_out(logic [7:0] b);
      res.tx_valid = 1; res.tx_byte = b;
    endfunction

    function logic [7:0] frame_byte(int unsigned i);
      logic [47:0] t;
      t = frame >> (40 - 8 * (i % 6));
      return t[7:0];
    endfunction

    function void issue(logic [7:0] cmd, logic [31:0] arg);
      logic [7:0] crc;
      crc = (cmd == 0) ? 8'h95 : (cmd == 8) ? 8'h87 : 8'h01;
      frame = {8'h40 | {2'b00, cmd[5:0]}, arg, crc};
      if (cmd == 12) begin
        shift_out(frame_byte(0)); idx = 1; eng = E_FRAME;
      end else begin
        cs_high = 1; shift_out(8'hFF); eng = E_DESEL;
      end
    endfunction

    // Application commands go out as CMD55 first, the real one held back
    function void cmd_start(logic [7:0] cmd, logic [31:0] arg);
      if (cmd[7]) begin
        app_pend = 1; app_cmd = cmd & 8'h7F; app_arg = arg;
        issue(8'd55, 0);
      end else begin
        issue(cmd, arg);
      end
    endfunction

    function void finish(bit good);
      end_ok = good; cs_high = 1; shift_out(8'hFF); ph = P_END;
    endfunction

    function void init_end(logic [3:0] k);
      kind = k; finish(k != 0);
    endfunction

    function void v2_loop();
      if (init_ms > init_limit) init_end(0);
      else begin
        cmd_start(Acmd41Code, 32'h4000_0000); ph = P_V2LOOP;
      end
    endfunction

    function void v1_loop();
      if (init_ms > init_limit) init_end(0);
      else begin
        cmd_start(loop_cmd, 0); ph = P_V1LOOP;
      end
    endfunction

    function void wait_in(phase_e p);
      wait_ms = 0; shift_out(8'hFF); ph = p;
    endfunction

    function void rd_stop_or_end();
      if (job == REQ_CAP) finish(0);
      else if (loop_cmd == 18) begin
        cmd_start(8'd12, 0); ph = P_STOP;
      end else finish(blocks == 0);
    endfunction

    function void data_fail();
      if (loop_cmd == 24) finish(0);
      else wait_in(P_STREADY);
    endfunction

    // Decode sector count from the CSD (v2 layout or v1 mult/read_bl_len)
    function logic [31:0] capacity();
      logic [31:0] s;
      int unsigned n;
      if (csd[0][7:6] == 2'b01) begin
        s = csd[9] + (32'(csd[8]) << 8) + (32'(csd[7] & 8'h3F) << 16) + 1;
        return s << 10;
      end
      n = (csd[5] & 15) + csd[10][7] + ((csd[9] & 3) << 1) + 2;
      s = (csd[8] >> 6) + (32'(csd[7]) << 2) + (32'(csd[6] & 3) << 10) + 1;
      return (n >= 9) ? s << (n - 9) : s >> (9 - n);
    endfunction

    function void dispatch(logic [7:0] r);
      case (ph)
        P_CMD0:
          if (r == 1) begin
            init_ms = 0; cmd_start(8'd8, 32'h1AA); ph = P_CMD8;
          end else init_end(0);
        P_CMD8:
          if (r == 1) begin
            idx = 0; reply = 0; shift_out(8'hFF); ph = P_R7;
          end else begin
            cmd_start(Acmd41Code, 0); ph = P_V1PROBE;
          end
        P_V2LOOP:
          if (r != 0) v2_loop();
          else if (init_ms > init_limit) init_end(0);
          else begin
            cmd_start(8'd58, 0); ph = P_CMD58;
          end
        P_CMD58:
          if (r == 0) begin
            idx = 0; reply = 0; shift_out(8'hFF); ph = P_OCR;
          end else init_end(0);
        P_V1PROBE: begin
          loop_cmd = (r <= 1) ? Acmd41Code : 8'h01;
          v1_loop();
        end
        P_V1LOOP:
          if (r != 0) v1_loop();
          else if (init_ms > init_limit) init_end(0);
          else begin
            cmd_start(8'd16, SectorBytes); ph = P_CMD16;
          end
        P_CMD16:
          init_end(r != 0 ? 4'd0 : (loop_cmd == Acmd41Code ? KindSd1 : KindMmc));
        P_RDCMD:
          if (r == 0) wait_in(P_TOKEN);
          else finish(0);
        P_STOP: finish(blocks == 0);
        P_ACMD23: begin
          cmd_start(8'd25, addr); ph = P_WRCMD;
        end
        P_WRCMD:
          if (r == 0) wait_in(P_WRREADY);
          else finish(0);
        default: finish(0);
      endcase
    endfunction

    function void cmd_done(logic [7:0] r);
      if (app_pend) begin
        app_pend = 0;
        if (r > 1) dispatch(r);
        else issue(app_cmd, app_arg);
      end else dispatch(r);
    endfunction

    // Command framing: deselect, select, ready wait, six bytes, a stuff byte after CMD12, R1 poll
    function void eng_rx(logic [7:0] rx);
      case (eng)
        E_DESEL: begin
          cs_high = 0; shift_out(8'hFF); eng = E_SEL;
        end
        E_SEL: begin
          wait_ms = 0; shift_out(8'hFF); eng = E_READY;
        end
        E_READY:
          if (rx == 8'hFF) begin
            shift_out(frame_byte(0)); idx = 1; eng = E_FRAME;
          end else if (wait_ms > ready_limit) begin
            cs_high = 1; shift_out(8'hFF); eng = E_FAIL;
          end else shift_out(8'hFF);
        E_FAIL: begin
          eng = E_OFF; cmd_done(8'hFF);
        end
        E_FRAME:
          if (idx < 6) begin
            shift_out(frame_byte(idx)); idx++;
          end else if ((frame_byte(0) & 8'h3F) == 12) begin
            shift_out(8'hFF); eng = E_STUFF;
          end else begin
            polls = poll_limit; shift_out(8'hFF); eng = E_POLL;
          end
        E_STUFF: begin
          polls = poll_limit; shift_out(8'hFF); eng = E_POLL;
        end
        default: begin
          polls = polls - 1;
          if (rx[7] && polls != 0) shift_out(8'hFF);
          else begin
            eng = E_OFF; cmd_done(rx);
          end
        end
      endcase
    endfunction

    // Data-level phases: replies, tokens, sector bytes, write responses
    function void hl_rx(logic [7:0] rx);
      int unsigned lim;
      bit acc;
      lim = (job == REQ_CAP) ? CsdBytes : SectorBytes;
      case (ph)
        P_WAKE:
          if (idx < wake_count) begin
            shift_out(8'hFF); idx++;
          end else begin
            cmd_start(8'd0, 0); ph = P_CMD0;
          end
        P_R7, P_OCR: begin
          reply = (reply << 8) | rx;
          idx++;
          if (idx < 4) shift_out(8'hFF);
          else if (ph == P_OCR) init_end(reply[30] ? (KindSd2 | KindBlk) : KindSd2);
          else if (reply[15:0] == 16'h01AA) v2_loop();
          else init_end(0);
        end
        P_TOKEN:
          if (rx == 8'hFF && wait_ms <= token_limit) shift_out(8'hFF);
          else if (rx == 8'hFE) begin
            idx = 0; shift_out(8'hFF); ph = P_DATA;
          end else rd_stop_or_end();
        P_DATA: begin
          if (job == REQ_CAP) csd[idx % CsdBytes] = rx;
          else begin
            res.rd_valid = 1; res.rd_byte = rx;
          end
          idx++;
          shift_out(8'hFF);
          if (idx >= lim) begin
            idx = 0; ph = P_CRC;
          end
        end
        P_CRC: begin
          idx++;
          if (idx < 2) shift_out(8'hFF);
          else if (job == REQ_CAP) begin
            reply = capacity(); finish(1);
          end else begin
            blocks = blocks - 1;
            if (blocks != 0) wait_in(P_TOKEN);
            else rd_stop_or_end();
          end
        end
        P_WRREADY:
          if (rx == 8'hFF) begin
            shift_out(loop_cmd == 24 ? 8'hFE : 8'hFC); ph = P_WRTOK;
          end else if (wait_ms > ready_limit) data_fail();
          else shift_out(8'hFF);
        P_WRTOK: begin
          idx = 0; res.wr_need = 1; ph = P_WRNEED;
        end
        P_WRDATA:
          if (idx < SectorBytes) begin
            res.wr_need = 1; ph = P_WRNEED;
          end else begin
            idx = 0; shift_out(8'hFF); ph = P_WRCRC;
          end
        P_WRCRC: begin
          idx++;
          shift_out(8'hFF);
          if (idx >= 2) ph = P_WRRESP;
        end
        P_WRRESP: begin
          acc = (rx & 8'h1F) == 8'h05;
          if (acc) blocks = blocks - 1;
          if (loop_cmd == 24) finish(blocks == 0);
          else if (acc && blocks != 0) wait_in(P_WRREADY);
          else wait_in(P_STREADY);
        end
        P_STREADY:
          if (rx == 8'hFF) begin
            shift_out(8'hFD); ph = P_STTOK;
          end else if (wait_ms > ready_limit) finish(0);
          else shift_out(8'hFF);
        P_STTOK: finish(blocks == 0);
        P_SYSEL: wait_in(P_SYRDY);
        P_SYRDY:
          if (rx == 8'hFF) finish(1);
          else if (wait_ms > ready_limit) begin
            cs_high = 1; shift_out(8'hFF); ph = P_SYDES;
          end else shift_out(8'hFF);
        P_SYDES: finish(0);
        P_END: begin
          res.done_res = 1; res.ok = end_ok;
          res.sector_total = (job == REQ_CAP && end_ok) ? reply : 0;
          if (end_ok) requests_ok++;
          if (job == REQ_INIT) slow_clk = 0;
          ph = P_IDLE;
        end
        default: ;
      endcase
    endfunction

    function void start(req_e rq, logic [31:0] sector, logic [21:0] count);
      logic [31:0] a;
      a = kind[3] ? sector : sector << 9;
      if ((rq == REQ_READ || rq == REQ_WRITE) && count == 0) begin
        res.done_res = 1; res.ok = 1;
        return;
      end
      requests_started++;
      job = rq;
      case (rq)
        REQ_INIT: begin
          slow_clk = 1; cs_high = 1;
          if (wake_count == 0) begin
            cmd_start(8'd0, 0); ph = P_CMD0;
          end else begin
            shift_out(8'hFF); idx = 1; ph = P_WAKE;
          end
        end
        REQ_READ: begin
          blocks = count; addr = a;
          loop_cmd = (count > 1) ? 8'd18 : 8'd17;
          cmd_start(loop_cmd, a); ph = P_RDCMD;
        end
        REQ_WRITE: begin
          blocks = count; addr = a;
          if (count == 1) begin
            loop_cmd = 8'd24; cmd_start(8'd24, a); ph = P_WRCMD;
          end else begin
            loop_cmd = 8'd25;
            if (kind & (KindSd1 | KindSd2)) begin
              cmd_start(Acmd23Code, 32'(count)); ph = P_ACMD23;
            end else begin
              cmd_start(8'd25, a); ph = P_WRCMD;
            end
          end
        end
        REQ_SYNC: begin
          cs_high = 0; shift_out(8'hFF); ph = P_SYSEL;
        end
        default: begin
          reply = 0; loop_cmd = 8'd9; cmd_start(8'd9, 0); ph = P_RDCMD;
        end
      endcase
    endfunction

    // Note one accepted input beat and queue the result it must cause
    function void note_beat(logic [2:0] rq, logic [31:0] sector, logic [21:0] count,
                            logic [7:0] rx, logic [7:0] hb, logic cp);
      res = '{default: '0};
      present = cp;
      if (!cp) kind = '0;
      if (rq <= REQ_CAP) begin
        if (ph == P_IDLE) start(req_e'(rq), sector, count);
      end else if (rq == REQ_SPI) begin
        if (eng != E_OFF) eng_rx(rx);
        else if (ph != P_IDLE && ph != P_WRNEED) hl_rx(rx);
      end else if (rq == REQ_TICK) begin
        if (init_ms < TmrMax) init_ms++;
        if (wait_ms < TmrMax) wait_ms++;
      end else if (ph == P_WRNEED) begin
        shift_out(hb); idx++; ph = P_WRDATA;
      end
      res.cs_level = cs_high;
      res.slow_clock = slow_clk;
      res.card_kind = kind;
      res.inserted = present;
      expected_results.push_back(res);
    endfunction

    function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_beat(spi_result_t act);
      spi_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual tx %0h",
                 $time, act.tx_byte);
        return;
      end
      e = expected_results.pop_front();
      results_checked++;
      cmp("tx_valid", e.tx_valid, act.tx_valid);
      cmp("tx_byte", e.tx_byte, act.tx_byte);
      cmp("cs_level", e.cs_level, act.cs_level);
      cmp("slow_clock", e.slow_clock, act.slow_clock);
      cmp("rd_valid", e.rd_valid, act.rd_valid);
      cmp("rd_byte", e.rd_byte, act.rd_byte);
      cmp("wr_need", e.wr_need, act.wr_need);
      cmp("done_res", e.done_res, act.done_res);
      cmp("ok", e.ok, act.ok);
      cmp("sector_total", e.sector_total, act.sector_total);
      cmp("card_kind", e.card_kind, act.card_kind);
      cmp("inserted", e.inserted, act.inserted);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [31:0] sector_address_i = '0;
  logic [21:0] block_count_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  host_byte_i = '0;
  logic        card_present_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        tx_valid_o, cs_level_o, slow_clock_o, rd_valid_o, wr_need_o;
  logic        done_res_o, ok_o, inserted_o;
  logic [7:0]  tx_byte_o, rd_byte_o;
  logic [31:0] sector_total_o;
  logic [3:0]  card_kind_o;

  always #5 clk_i = ~clk_i;

  sd_card_spi_host_sequencer i_dut (.*);

  spi_host_scoreboard sb = new();
  bit          no_idle = 0;
  bit          draining = 0;
  int unsigned idle_cycles = 0;

  // Check every result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat('{tx_valid_o, tx_byte_o, cs_level_o, slow_clock_o, rd_valid_o,
                      rd_byte_o, wr_need_o, done_res_o, ok_o, sector_total_o,
                      card_kind_o, inserted_o});
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Alternate between stretches with and without idling
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) no_idle <= ~no_idle;
  end

  // Result side: stall a random number of cycles before each beat
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_ready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic drive_beat(logic [2:0] rq, logic [31:0] sa, logic [21:0] bc,
                            logic [7:0] rx, logic [7:0] hb, logic cp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= rq; sector_address_i <= sa; block_count_i <= bc;
    rx_byte_i <= rx; host_byte_i <= hb; card_present_i <= cp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(rq, sa, bc, rx, hb, cp);
  endtask

  // Card reply that mostly moves the current sequence forward
  function automatic logic [7:0] card_reply();
    logic [7:0] r7 [4] = '{8'h00, 8'h00, 8'h01, 8'hAA};
    logic [7:0] v1 [3] = '{8'h00, 8'h01, 8'h05};
    if (sb.eng == E_READY) return 8'hFF;
    if (sb.eng == E_POLL) begin
      if (!draining && $urandom_range(0, 3) == 0) return 8'h80 | 8'($urandom);
      if (sb.app_pend) return 8'($urandom_range(0, 1));
      case (sb.ph)
        P_CMD0: return 8'h01;
        P_CMD8: return (!draining && $urandom_range(0, 2) == 0) ? 8'h05 : 8'h01;
        P_V1PROBE: return v1[$urandom_range(0, 2)];
        P_V2LOOP, P_V1LOOP:
          return (!draining && $urandom_range(0, 2) == 0) ? 8'h01 : 8'h00;
        default: return 8'h00;
      endcase
    end
    if (sb.eng != E_OFF) return 8'($urandom);
    case (sb.ph)
      P_R7: return r7[sb.idx % 4];
      P_TOKEN:
        if (draining) return 8'h00;
        else return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'hFE;
      P_WRREADY, P_STREADY, P_SYRDY:
        return (draining || $urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
      P_WRRESP: return draining ? 8'h00 : ((8'($urandom) & 8'hE0) | 8'h05);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [21:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 22'd1;
    if (r < 75) return 22'($urandom_range(2, 3));
    if (r < 90) return 22'd0;
    return 22'($urandom);
  endfunction

  task automatic random_beat();
    logic [2:0] rq;
    logic [7:0] rx;
    logic       cp;
    int         r;
    r = $urandom_range(0, 99);
    rq = REQ_SPI;
    rx = 8'($urandom);
    cp = draining || $urandom_range(0, 49) != 0;
    if (sb.ph == P_IDLE) begin
      if (sb.kind == 0 && r < 40) rq = REQ_INIT;
      else if (r < 80) rq = 3'($urandom_range(0, 4));
      else if (r < 90) rq = REQ_TICK;
      else if (r >= 95) rq = REQ_WBYTE;
    end else if (sb.ph == P_WRNEED) begin
      if (draining || r < 92) rq = REQ_WBYTE;
      else if (r < 96) rq = REQ_TICK;
    end else begin
      if (!draining && r < 8) rq = REQ_TICK;
      else if (!draining && r < 11) rq = 3'($urandom_range(0, 4));
      else if (draining || r >= 14) rx = card_reply();
    end
    drive_beat(rq, $urandom, pick_count(), rx, 8'($urandom), cp);
  endtask

  // Run a phase, then answer like a good card until the sequencer is idle
  task automatic run_phase(int n);
    repeat (n) random_beat();
    draining = 1;
    while (sb.ph != P_IDLE) random_beat();
    draining = 0;
  endtask

  // Write registers only once every result has come out
  task automatic write_regs(logic [15:0] rdy, logic [15:0] tok, logic [15:0] ini,
                            logic [7:0] pol, logic [7:0] wak);
    logic [15:0] vals [5];
    vals = '{rdy, tok, ini, 16'(pol), 16'(wak)};
    in_valid_i <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1; cfg_index_i <= 3'(i); cfg_data_i <= vals[i];
      sb.set_reg(cfg_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: stray beats, zero counts, absent card, sync with busy request
    drive_beat(REQ_TICK, '0, '0, '0, '0, 1);
    drive_beat(REQ_SPI, '0, '0, 8'h00, '0, 1);
    drive_beat(REQ_WBYTE, '0, '0, '0, 8'hFF, 1);
    drive_beat(REQ_READ, 32'hFFFF_FFFF, 22'd0, '0, '0, 1);
    drive_beat(REQ_WRITE, 32'h0, 22'd0, 8'hFF, '0, 1);
    drive_beat(REQ_TICK, '0, 22'h3F_FFFF, '0, '0, 0);
    drive_beat(REQ_SYNC, '0, '0, '0, '0, 1);
    drive_beat(REQ_SPI, '0, '0, 8'h12, '0, 1);
    drive_beat(REQ_SPI, '0, '0, 8'h00, '0, 1);
    drive_beat(REQ_INIT, '0, '0, '0, '0, 1);
    drive_beat(REQ_SPI, '0, '0, 8'hFF, '0, 1);
    drive_beat(REQ_SPI, '0, '0, 8'h34, '0, 1);
    drive_beat(REQ_INIT, '0, '0, '0, '0, 1);
    draining = 1;
    while (sb.ph != P_IDLE) random_beat();
    draining = 0;
    drive_beat(REQ_CAP, '0, '0, '0, '0, 1);
    run_phase(330);

    // Smallest limits: timeouts after a tick or two
    write_regs(16'd1, 16'd1, 16'd1, 8'd1, 8'd1);
    run_phase(330);
    // Largest limits
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    run_phase(330);
    // Zero polls allows 256, zero wake skips the wake bytes
    write_regs(16'd3, 16'd2, 16'd5, 8'd0, 8'd0);
    run_phase(330);
    write_regs(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
               16'($urandom_range(1, 40)), 8'($urandom_range(1, 12)),
               8'($urandom_range(0, 12)));
    run_phase(330);

    in_valid_i <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("Checked %0d result beats; %0d requests started, %0d finished ok.",
             sb.results_checked, sb.requests_started, sb.requests_ok);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sd_card_spi_host_sequencer.f =====
rtl/sdspi_pkg.sv
rtl/sd_card_spi_host_sequencer.sv
verif/tb_sd_card_spi_host_sequencer.sv
